>>> rtl/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared types, fixed-point constants and the arctangent table of the
// polar/rectangular CORDIC converter.
// ----------------------------------------------------------------------------
`default_nettype none

package prc_pkg;

    localparam int ITERATIONS_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 16;

    // coordinate fraction bits carried through the iterations
    localparam int GUARD      = 8;
    // inverse CORDIC gain, 2^-20 units
    localparam int INVK_Q20   = 636751;
    localparam int INVK_FRAC  = 20;
    localparam int ANGLE_BITS = 16;
    localparam int TABLE_LEN  = 32;
    // angle accumulator: 2^-32 turn units, two bits of headroom
    localparam int Z_WIDTH    = 34;
    localparam int Z_FRAC     = 32 - ANGLE_BITS;

    localparam logic signed [Z_WIDTH-1:0] QUARTER_TURN = Z_WIDTH'(64'h4000_0000);
    localparam logic signed [Z_WIDTH-1:0] HALF_TURN    = Z_WIDTH'(64'h8000_0000);

    // atan(2^-i) in 2^-32 turn units
    localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef enum logic {
        OP_TO_RECT  = 1'b0,
        OP_TO_POLAR = 1'b1
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
        logic zero;
    } t_ctrl;

endpackage

`default_nettype wire

>>> rtl/prc_cordic_stage.sv
// ----------------------------------------------------------------------------
// prc_cordic_stage
// One registered CORDIC micro-rotation with a fixed shift; rotation or
// vectoring direction chosen per request.
// ----------------------------------------------------------------------------
`default_nettype none

module prc_cordic_stage
    import prc_pkg::*;
#(
    parameter int DW    = COORD_WIDTH_DEF + GUARD + 3,
    parameter int SHIFT = 0
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_ctrl                     i_ctrl,
    input  logic signed [DW-1:0]      i_x,
    input  logic signed [DW-1:0]      i_y,
    input  logic signed [Z_WIDTH-1:0] i_z,
    output t_ctrl                     o_ctrl,
    output logic signed [DW-1:0]      o_x,
    output logic signed [DW-1:0]      o_y,
    output logic signed [Z_WIDTH-1:0] o_z
);

    localparam logic signed [Z_WIDTH-1:0] ATAN_STEP = Z_WIDTH'(ATAN_TURNS[SHIFT]);

    t_ctrl                     r_ctrl;
    logic signed [DW-1:0]      r_x, r_y, n_x, n_y;
    logic signed [Z_WIDTH-1:0] r_z, n_z;
    logic signed [DW-1:0]      w_dx, w_dy;
    logic                      w_down;

    assign w_dx = i_y >>> SHIFT;
    assign w_dy = i_x >>> SHIFT;
    // vectoring drives y to zero, rotation drives the angle to zero
    assign w_down = (i_ctrl.op == OP_TO_POLAR) ? i_y[DW-1] : ~i_z[Z_WIDTH-1];

    always_comb begin
        if (w_down) begin
            n_x = i_x - w_dx;
            n_y = i_y + w_dy;
            n_z = i_z - ATAN_STEP;
        end else begin
            n_x = i_x + w_dx;
            n_y = i_y - w_dy;
            n_z = i_z + ATAN_STEP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctrl = r_ctrl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

`default_nettype wire

>>> rtl/polar_rect_converter.sv
// ----------------------------------------------------------------------------
// polar_rect_converter
// Pipelined CORDIC converter between polar and rectangular coordinates.
// ----------------------------------------------------------------------------
// A request is taken on every clock edge with start high; busy stays low, so
// one conversion can enter each cycle. Its result appears on o_out_a and
// o_out_b with o_strobe high for one cycle, after one input multiply stage,
// one range reduction stage, one register stage per CORDIC iteration, one
// gain multiply stage and one rounding and saturation stage. Results cannot
// be held off; the receiver must take each one in its strobe cycle. Op 0 turns
// a magnitude and a 16-bit binary angle into x and y; op 1 turns x and y into
// the magnitude and the angle, with zero for the zero vector.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_rect_converter
    import prc_pkg::*;
#(
    parameter int ITERATIONS  = ITERATIONS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_op,
    input  logic signed [COORD_WIDTH-1:0] i_in_a,
    input  logic signed [COORD_WIDTH-1:0] i_in_b,
    output logic                          o_strobe,
    output logic signed [COORD_WIDTH:0]   o_out_a,
    output logic signed [COORD_WIDTH-1:0] o_out_b
);

    localparam int W     = COORD_WIDTH;
    localparam int NITER = (ITERATIONS > TABLE_LEN) ? TABLE_LEN : ITERATIONS;
    localparam int DW    = W + GUARD + 3;
    localparam int PW    = W + INVK_FRAC + 1;
    localparam int MW    = DW + INVK_FRAC + 1;
    localparam int SH_IN = INVK_FRAC - GUARD;
    localparam int SH_M  = INVK_FRAC + GUARD;
    localparam int LAT   = NITER + 4;

    localparam logic signed [PW-1:0]      INVK_P = PW'(INVK_Q20);
    localparam logic signed [MW-1:0]      INVK_M = MW'(INVK_Q20);
    localparam logic signed [PW-1:0]      RND_P  = PW'(2 ** (SH_IN - 1));
    localparam logic signed [DW-1:0]      RND_X  = DW'(2 ** (GUARD - 1));
    localparam logic signed [MW-1:0]      RND_M  = MW'(2 ** (SH_M - 1));
    localparam logic signed [Z_WIDTH-1:0] RND_Z  = Z_WIDTH'(2 ** (Z_FRAC - 1));

    // ---------------- stage A: input register and gain pre-scale ----------
    t_ctrl                r_a_ctrl;
    logic signed [PW-1:0] r_a_prod;
    logic signed [W-1:0]  r_a_a, r_a_b;
    logic signed [PW-1:0] w_a_ext;

    assign busy    = 1'b0;
    assign w_a_ext = PW'(i_in_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_ctrl <= '0;
        end else begin
            r_a_ctrl.valid <= start && !busy;
            r_a_ctrl.op    <= t_op'(i_op);
            r_a_ctrl.zero  <= 1'b0;
        end
        r_a_prod <= w_a_ext * INVK_P;
        r_a_a    <= i_in_a;
        r_a_b    <= i_in_b;
    end

    // ---------------- stage B: range reduction ----------------------------
    t_ctrl                     r_b_ctrl, n_b_ctrl;
    logic signed [DW-1:0]      r_b_x, r_b_y, n_b_x, n_b_y;
    logic signed [Z_WIDTH-1:0] r_b_z, n_b_z, w_z0;
    logic signed [PW-1:0]      w_prnd;
    logic signed [DW-1:0]      w_px, w_vx, w_vy;
    logic [ANGLE_BITS-1:0]     w_ang;

    assign w_prnd = (r_a_prod + RND_P) >>> SH_IN;
    assign w_px   = DW'(w_prnd);
    assign w_vx   = DW'(r_a_a) <<< GUARD;
    assign w_vy   = DW'(r_a_b) <<< GUARD;
    assign w_ang  = ANGLE_BITS'($unsigned(r_a_b));
    assign w_z0   = {{(Z_WIDTH - ANGLE_BITS - Z_FRAC){w_ang[ANGLE_BITS-1]}},
                     w_ang, Z_FRAC'(0)};

    always_comb begin
        n_b_ctrl      = r_a_ctrl;
        n_b_ctrl.zero = 1'b0;
        n_b_x         = '0;
        n_b_y         = '0;
        n_b_z         = '0;
        if (r_a_ctrl.op == OP_TO_POLAR) begin
            n_b_ctrl.zero = (r_a_a == '0) && (r_a_b == '0);
            // fold the left half-plane onto the right
            if (r_a_a[W-1]) begin
                n_b_x = -w_vx;
                n_b_y = -w_vy;
                n_b_z = HALF_TURN;
            end else begin
                n_b_x = w_vx;
                n_b_y = w_vy;
            end
        end else begin
            priority if (w_z0 > QUARTER_TURN) begin
                n_b_x = -w_px;
                n_b_z = w_z0 - HALF_TURN;
            end else if (w_z0 < -QUARTER_TURN) begin
                n_b_x = -w_px;
                n_b_z = w_z0 + HALF_TURN;
            end else begin
                n_b_x = w_px;
                n_b_z = w_z0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_ctrl <= '0;
        end else begin
            r_b_ctrl <= n_b_ctrl;
        end
        r_b_x <= n_b_x;
        r_b_y <= n_b_y;
        r_b_z <= n_b_z;
    end

    // ---------------- CORDIC iterations -----------------------------------
    t_ctrl                     w_c_ctrl [NITER+1];
    logic signed [DW-1:0]      w_c_x    [NITER+1];
    logic signed [DW-1:0]      w_c_y    [NITER+1];
    logic signed [Z_WIDTH-1:0] w_c_z    [NITER+1];

    assign w_c_ctrl[0] = r_b_ctrl;
    assign w_c_x[0]    = r_b_x;
    assign w_c_y[0]    = r_b_y;
    assign w_c_z[0]    = r_b_z;

    for (genvar g = 0; g < NITER; g++) begin : g_iter
        prc_cordic_stage #(
            .DW    (DW),
            .SHIFT (g)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_c_ctrl[g]),
            .i_x     (w_c_x[g]),
            .i_y     (w_c_y[g]),
            .i_z     (w_c_z[g]),
            .o_ctrl  (w_c_ctrl[g+1]),
            .o_x     (w_c_x[g+1]),
            .o_y     (w_c_y[g+1]),
            .o_z     (w_c_z[g+1])
        );
    end

    // ---------------- stage D: magnitude gain correction ------------------
    t_ctrl                     r_d_ctrl;
    logic signed [MW-1:0]      r_d_mag;
    logic signed [DW-1:0]      r_d_x, r_d_y;
    logic signed [Z_WIDTH-1:0] r_d_z;
    logic signed [MW-1:0]      w_d_ext;

    assign w_d_ext = MW'(w_c_x[NITER]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_ctrl <= '0;
        end else begin
            r_d_ctrl <= w_c_ctrl[NITER];
        end
        r_d_mag <= w_d_ext * INVK_M;
        r_d_x   <= w_c_x[NITER];
        r_d_y   <= w_c_y[NITER];
        r_d_z   <= w_c_z[NITER];
    end

    // ---------------- stage E: round, saturate, output register -----------
    logic                      r_strobe;
    logic signed [W:0]         r_out_a, n_out_a;
    logic signed [W-1:0]       r_out_b, n_out_b;
    logic signed [DW-1:0]      w_xr, w_yr;
    logic signed [MW-1:0]      w_mr;
    logic signed [Z_WIDTH-1:0] w_zr;
    logic signed [W-1:0]       w_x_sat, w_y_sat;
    logic signed [W:0]         w_m_sat;
    logic                      w_x_ok, w_y_ok, w_m_ok;

    assign w_xr = (r_d_x + RND_X) >>> GUARD;
    assign w_yr = (r_d_y + RND_X) >>> GUARD;
    assign w_mr = (r_d_mag + RND_M) >>> SH_M;
    assign w_zr = (r_d_z + RND_Z) >>> Z_FRAC;

    // in range when every bit above the kept sign bit copies it
    assign w_x_ok  = (&w_xr[DW-1:W-1]) || !(|w_xr[DW-1:W-1]);
    assign w_y_ok  = (&w_yr[DW-1:W-1]) || !(|w_yr[DW-1:W-1]);
    assign w_m_ok  = (&w_mr[MW-1:W]) || !(|w_mr[MW-1:W]);
    assign w_x_sat = w_x_ok ? w_xr[W-1:0] : {w_xr[DW-1], {(W-1){~w_xr[DW-1]}}};
    assign w_y_sat = w_y_ok ? w_yr[W-1:0] : {w_yr[DW-1], {(W-1){~w_yr[DW-1]}}};
    assign w_m_sat = w_m_ok ? w_mr[W:0] : {w_mr[MW-1], {W{~w_mr[MW-1]}}};

    always_comb begin
        if (r_d_ctrl.op == OP_TO_RECT) begin
            n_out_a = {w_x_sat[W-1], w_x_sat};
            n_out_b = w_y_sat;
        end else if (r_d_ctrl.zero) begin
            n_out_a = '0;
            n_out_b = '0;
        end else begin
            n_out_a = w_m_sat;
            // angle wraps to 16 bits
            n_out_b = W'(w_zr[ANGLE_BITS-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_d_ctrl.valid;
        end
        r_out_a <= n_out_a;
        r_out_b <= n_out_b;
    end

    assign o_strobe = r_strobe;
    assign o_out_a  = r_out_a;
    assign o_out_b  = r_out_b;

`ifndef SYNTHESIS
    a_latency_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_strobe)
        else $error("request did not produce a result at the fixed latency");

    a_latency_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("result strobe without a matching request");

    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_op && i_in_a == '0 && i_in_b == '0)
            |-> ##LAT (o_out_a == '0 && o_out_b == '0))
        else $error("zero vector did not give a zero result");

    a_rect_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !i_op) |-> ##LAT (o_out_a[W] == o_out_a[W-1]))
        else $error("rectangular x left the coordinate range");

    a_mag_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_op) |-> ##LAT !o_out_a[W])
        else $error("magnitude came out negative");
`endif

endmodule

`default_nettype wire
